// ===== rtl/rpvg_pkg.sv =====
// ---------------------------------------------------------------------------
// Regular polygon vertex generator package
// Shared constants, the CORDIC arctangent table and the controller/datapath
// command and status types.
// ---------------------------------------------------------------------------
package rpvg_pkg;

    localparam int MAX_SIDES_DEF  = 64;
    localparam int PHASE_BITS_DEF = 16;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);

    // CORDIC working width and the Q30 start vector length (gain compensated).
    localparam int                    TRIG_W      = 32;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam int                 COORD_W   = 16;
    localparam logic signed [19:0] COORD_MAX = 20'sd32767;
    localparam logic signed [19:0] COORD_MIN = -20'sd32768;

    localparam int SIDE_IN_W   = 7;
    localparam int RADIUS_W    = 15;
    localparam int MIN_SIDES   = 3;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [TRIG_W-1:0] atan_turn(input logic [STAGE_W-1:0] k);
        logic [TRIG_W-1:0] v;
        unique case (k)
            4'd0:  v = 32'h20000000;
            4'd1:  v = 32'h12E4051E;
            4'd2:  v = 32'h09FB385B;
            4'd3:  v = 32'h051111D4;
            4'd4:  v = 32'h028B0D43;
            4'd5:  v = 32'h0145D7E1;
            4'd6:  v = 32'h00A2F61E;
            4'd7:  v = 32'h00517C55;
            4'd8:  v = 32'h0028BE53;
            4'd9:  v = 32'h00145F2F;
            4'd10: v = 32'h000A2F98;
            4'd11: v = 32'h000517CC;
            4'd12: v = 32'h00028BE6;
            4'd13: v = 32'h000145F3;
            4'd14: v = 32'h0000A2FA;
            4'd15: v = 32'h0000517D;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic load;      // capture a new polygon request
        logic div_step;  // one bit of the phase step division
        logic vstart;    // start the rotation for the next vertex
        logic rot_step;  // one CORDIC iteration
        logic mul_x;     // radius times cosine
        logic mul_y;     // place x, radius times sine
        logic fin_y;     // place y
        logic out_load;  // move the finished vertex to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic few;       // requested side count is below three
        logic div_last;  // final division step
        logic rot_last;  // final CORDIC iteration
        logic vlast;     // current vertex closes the polygon
        logic out_free;  // output register can take a vertex this cycle
    } t_dp_stat;

endpackage

// ===== rtl/regular_polygon_vertex_generator.sv =====
// ---------------------------------------------------------------------------
// Regular polygon vertex generator
// Takes one polygon request (side count, radius, center) and emits its
// vertices in order, each rounded to a signed 16-bit integer (Q15.0) and saturated.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ---------------------------------------
//  input     i_in_valid / o_in_ready    i_side_count i_radius i_center_x/_y
//  output    o_out_valid / i_out_ready  o_vertex_x o_vertex_y o_last_vertex
//
// A request first divides a full turn by the side count, one bit per cycle,
// then takes each vertex through a setup step, the CORDIC iterations, the
// single shared multiplier with rounding for x and then for y, and a move
// into the output register. The next vertex is computed while the previous
// one waits in the output register; a stalled output holds the sequencer
// only at the handoff. A side count below three is accepted, produces
// nothing and leaves the block idle. Reset is synchronous and active low;
// it clears the sequencer and the output valid flag, so no transaction is
// pending after reset.
// ---------------------------------------------------------------------------
module regular_polygon_vertex_generator #(
    parameter int MAX_SIDES  = rpvg_pkg::MAX_SIDES_DEF,
    parameter int PHASE_BITS = rpvg_pkg::PHASE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [rpvg_pkg::SIDE_IN_W-1:0]       i_side_count,
    input  logic [rpvg_pkg::RADIUS_W-1:0]        i_radius,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_center_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rpvg_pkg::COORD_W-1:0]  o_vertex_x,
    output logic signed [rpvg_pkg::COORD_W-1:0]  o_vertex_y,
    output logic                                 o_last_vertex
);
    import rpvg_pkg::*;

    // The controller issues one command per cycle unless idle or stalled; the
    // datapath reports back when a division, a rotation or a polygon is complete.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    rpvg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath owns the output register, so the output transaction
    // completes independently of the sequencer.
    rpvg_dpath #(
        .MAX_SIDES  (MAX_SIDES),
        .PHASE_BITS (PHASE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_side_count  (i_side_count),
        .i_radius      (i_radius),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_vertex_x    (o_vertex_x),
        .o_vertex_y    (o_vertex_y),
        .o_last_vertex (o_last_vertex)
    );

endmodule

// ===== rtl/rpvg_ctrl.sv =====
// ---------------------------------------------------------------------------
// Regular polygon vertex generator controller
// Sequences division, rotation, scaling and output of each vertex.
// ---------------------------------------------------------------------------
module rpvg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rpvg_pkg::t_dp_stat i_stat,
    output rpvg_pkg::t_dp_cmd  o_cmd
);
    import rpvg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_VSTART = 3'd2;
    localparam logic [2:0] S_ROT    = 3'd3;
    localparam logic [2:0] S_MULX   = 3'd4;
    localparam logic [2:0] S_MULY   = 3'd5;
    localparam logic [2:0] S_FINY   = 3'd6;
    localparam logic [2:0] S_PUSH   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.few) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_VSTART;
                end
            end
            S_VSTART: begin
                o_cmd.vstart = 1'b1;
                n_state      = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (i_stat.rot_last) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state     = S_FINY;
            end
            S_FINY: begin
                o_cmd.fin_y = 1'b1;
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_stat.vlast ? S_IDLE : S_VSTART;
                end
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/rpvg_dpath.sv =====
// ---------------------------------------------------------------------------
// Regular polygon vertex generator datapath
// Step divider, phase accumulator, iterative CORDIC, shared multiplier,
// rounding and saturation, and the output register.
// ---------------------------------------------------------------------------
module rpvg_dpath #(
    parameter int MAX_SIDES  = rpvg_pkg::MAX_SIDES_DEF,
    parameter int PHASE_BITS = rpvg_pkg::PHASE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rpvg_pkg::t_dp_cmd                    i_cmd,
    output rpvg_pkg::t_dp_stat                   o_stat,
    input  logic [rpvg_pkg::SIDE_IN_W-1:0]       i_side_count,
    input  logic [rpvg_pkg::RADIUS_W-1:0]        i_radius,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_center_y,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [rpvg_pkg::COORD_W-1:0]  o_vertex_x,
    output logic signed [rpvg_pkg::COORD_W-1:0]  o_vertex_y,
    output logic                                 o_last_vertex
);
    import rpvg_pkg::*;

    localparam int SW     = $clog2(MAX_SIDES + 1);
    localparam int IW     = $clog2(MAX_SIDES);
    localparam int CW     = $clog2(PHASE_BITS + 1);
    localparam int PROD_W = RADIUS_W + 1 + TRIG_W + 1;

    logic [SW-1:0]               r_n;
    logic [RADIUS_W-1:0]         r_radius;
    logic signed [COORD_W-1:0]   r_cx;
    logic signed [COORD_W-1:0]   r_cy;
    logic [CW-1:0]               r_div_cnt;
    logic [SW-1:0]               r_rem;
    logic [PHASE_BITS-1:0]       r_step;
    logic [PHASE_BITS-1:0]       r_phase;
    logic [SW-1:0]               r_prem;
    logic [IW-1:0]               r_idx;
    logic                        r_vlast;
    logic [1:0]                  r_quad;
    logic signed [TRIG_W-1:0]    r_x;
    logic signed [TRIG_W-1:0]    r_y;
    logic signed [TRIG_W-1:0]    r_z;
    logic [STAGE_W-1:0]          r_k;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [COORD_W-1:0]   r_vx;
    logic signed [COORD_W-1:0]   r_vy;
    logic                        r_ovalid;
    logic signed [COORD_W-1:0]   r_ox;
    logic signed [COORD_W-1:0]   r_oy;
    logic                        r_olast;

    // Rounds a Q30-scaled product to an integer, adds the center and saturates to signed Q15.0.
    function automatic logic signed [COORD_W-1:0] place(
        input logic signed [PROD_W-1:0]  prod,
        input logic signed [COORD_W-1:0] ctr
    );
        logic signed [PROD_W-1:0] rnd;
        logic signed [19:0]       s;
        rnd = prod + (PROD_W'(1) <<< 29);
        s   = 20'($signed(rnd[PROD_W-1:30])) + 20'(ctr);
        if (s > COORD_MAX) begin
            return COORD_W'(COORD_MAX);
        end else if (s < COORD_MIN) begin
            return COORD_W'(COORD_MIN);
        end
        return s[COORD_W-1:0];
    endfunction

    // Side count clamp and the lone dividend bit of a full turn.
    logic [SW-1:0]   n_clamped;
    logic [SW:0]     div_trial;
    logic            div_fit;
    logic [SW:0]     prem_sum;
    logic            prem_wrap;

    always_comb begin
        if (i_side_count > SIDE_IN_W'(MAX_SIDES)) begin
            n_clamped = SW'(MAX_SIDES);
        end else begin
            n_clamped = i_side_count[SW-1:0];
        end
        div_trial = {r_rem, (r_div_cnt == '0)};
        div_fit   = (div_trial >= {1'b0, r_n});
        prem_sum  = {1'b0, r_prem} + {1'b0, r_rem};
        prem_wrap = (prem_sum >= {1'b0, r_n});
    end

    // CORDIC iteration and quadrant mapping.
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [TRIG_W-1:0] at;
    logic signed [TRIG_W:0]   xe;
    logic signed [TRIG_W:0]   ye;
    logic signed [TRIG_W:0]   cos_v;
    logic signed [TRIG_W:0]   sin_v;
    logic signed [TRIG_W:0]   mul_trig;

    always_comb begin
        dx = r_y >>> r_k;
        dy = r_x >>> r_k;
        at = $signed(atan_turn(r_k));
        xe = {r_x[TRIG_W-1], r_x};
        ye = {r_y[TRIG_W-1], r_y};
        unique case (r_quad)
            2'd0: begin cos_v = xe;  sin_v = ye;  end
            2'd1: begin cos_v = -ye; sin_v = xe;  end
            2'd2: begin cos_v = -xe; sin_v = -ye; end
            2'd3: begin cos_v = ye;  sin_v = -xe; end
        endcase
        mul_trig = i_cmd.mul_x ? cos_v : sin_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n       <= n_clamped;
            r_radius  <= i_radius;
            r_cx      <= i_center_x;
            r_cy      <= i_center_y;
            r_div_cnt <= '0;
            r_rem     <= '0;
            r_step    <= '0;
            r_phase   <= '0;
            r_prem    <= n_clamped >> 1;
            r_idx     <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + CW'(1);
            r_rem     <= div_fit ? SW'(div_trial - {1'b0, r_n}) : div_trial[SW-1:0];
            r_step    <= {r_step[PHASE_BITS-2:0], div_fit};
        end
        if (i_cmd.vstart) begin
            r_quad  <= r_phase[PHASE_BITS-1 -: 2];
            r_x     <= CORDIC_GAIN;
            r_y     <= '0;
            r_z     <= {2'b00, r_phase[PHASE_BITS-3:0], {(32 - PHASE_BITS){1'b0}}};
            r_k     <= '0;
            r_vlast <= ({1'b0, r_idx} == SW'(r_n - SW'(1)));
            r_idx   <= r_idx + IW'(1);
            r_phase <= r_phase + r_step + PHASE_BITS'(prem_wrap);
            r_prem  <= prem_wrap ? SW'(prem_sum - {1'b0, r_n}) : prem_sum[SW-1:0];
        end
        if (i_cmd.rot_step) begin
            r_k <= r_k + STAGE_W'(1);
            if (!r_z[TRIG_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= $signed({1'b0, r_radius}) * mul_trig;
        end
        if (i_cmd.mul_y) begin
            r_vx <= place(r_prod, r_cx);
        end
        if (i_cmd.fin_y) begin
            r_vy <= place(r_prod, r_cy);
        end
        if (i_cmd.out_load) begin
            r_ox    <= r_vx;
            r_oy    <= r_vy;
            r_olast <= r_vlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stat.few      = (i_side_count < SIDE_IN_W'(MIN_SIDES));
    assign o_stat.div_last = (r_div_cnt == CW'(PHASE_BITS));
    assign o_stat.rot_last = (r_k == STAGE_W'(CORDIC_STAGES - 1));
    assign o_stat.vlast    = r_vlast;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_vertex_x    = r_ox;
    assign o_vertex_y    = r_oy;
    assign o_last_vertex = r_olast;

endmodule

// ===== rtl/rpvg_checker.sv =====
// ---------------------------------------------------------------------------
// Regular polygon vertex generator checker
// Port-level assertions on request and vertex transaction ordering.
// ---------------------------------------------------------------------------
module rpvg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [6:0]  i_side_count,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_vertex_x,
    input logic [15:0] o_vertex_y,
    input logic        o_last_vertex
);

    // No vertex is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled vertex holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_vertex_x) && $stable(o_vertex_y)
             && $stable(o_last_vertex)))
        else $error("stalled vertex changed");

    // A real polygon request keeps the input side busy.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_side_count >= 7'd3) |=> !o_in_ready)
        else $error("request accepted while a polygon is in progress");

    // A degenerate request is dropped without a vertex.
    a_few_sides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_side_count < 7'd3) |=>
            (o_in_ready && !$rose(o_out_valid)))
        else $error("degenerate request produced a vertex");

    // While a vertex other than the closing one is offered, the polygon is
    // still being generated and no new request is accepted.
    a_mid_polygon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_vertex) |-> !o_in_ready)
        else $error("input ready before polygon closed");

endmodule

bind regular_polygon_vertex_generator rpvg_checker u_rpvg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_side_count  (i_side_count),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_vertex_x    (o_vertex_x),
    .o_vertex_y    (o_vertex_y),
    .o_last_vertex (o_last_vertex)
);

// ===== test/vertex_checker.sv =====
// ---------------------------------------------------------------------------
// Polygon vertex checker
// Watches both channels of the vertex generator, predicts every vertex of
// each accepted polygon and compares the returned vertices in order.
// ---------------------------------------------------------------------------
module vertex_checker #(
    parameter int MAX_SIDES  = rpvg_pkg::MAX_SIDES_DEF,
    parameter int PHASE_BITS = rpvg_pkg::PHASE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [rpvg_pkg::SIDE_IN_W-1:0]       i_side_count,
    input  logic [rpvg_pkg::RADIUS_W-1:0]        i_radius,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_center_y,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_vertex_x,
    input  logic signed [rpvg_pkg::COORD_W-1:0]  i_vertex_y,
    input  logic                                 i_last_vertex,
    output int                                   o_mismatches,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic signed [rpvg_pkg::COORD_W-1:0] x;
        logic signed [rpvg_pkg::COORD_W-1:0] y;
        logic                                last;
        int unsigned                         polygon;
        int unsigned                         corner;
    } t_vertex;

    t_vertex expected_vertices[$];

    // Shadow of the block's state; it is tracked but not observable.
    logic [5:0]            vertex_index;
    logic [PHASE_BITS-1:0] phase_accumulator;
    logic [PHASE_BITS-1:0] phase_step;
    int unsigned           polygons_seen;

    initial begin
        o_mismatches      = 0;
        o_pending         = 0;
        polygons_seen     = 0;
        vertex_index      = '0;
        phase_accumulator = '0;
        phase_step        = '0;
    end

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic longint arctan_turn(input int k);
        case (k)
            0:       return 64'h20000000;
            1:       return 64'h12E4051E;
            2:       return 64'h09FB385B;
            3:       return 64'h051111D4;
            4:       return 64'h028B0D43;
            5:       return 64'h0145D7E1;
            6:       return 64'h00A2F61E;
            7:       return 64'h00517C55;
            8:       return 64'h0028BE53;
            9:       return 64'h00145F2F;
            10:      return 64'h000A2F98;
            11:      return 64'h000517CC;
            12:      return 64'h00028BE6;
            13:      return 64'h000145F3;
            14:      return 64'h0000A2FA;
            default: return 64'h0000517D;
        endcase
    endfunction

    // Rotation-mode CORDIC on the angle within the quadrant; the quadrant
    // itself is applied exactly afterwards. Arithmetic shifts of signed
    // values round toward minus infinity, as the hardware does.
    function automatic void rotate_turn(input logic [31:0] turn,
                                        output longint cos_q30,
                                        output longint sin_q30);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = rpvg_pkg::CORDIC_GAIN;
        y = 0;
        z = {34'd0, turn[29:0]};
        for (int k = 0; k < rpvg_pkg::CORDIC_STAGES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turn(k);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turn(k);
            end
        end
        case (turn[31:30])
            2'd0: begin
                cos_q30 = x;
                sin_q30 = y;
            end
            2'd1: begin
                cos_q30 = -y;
                sin_q30 = x;
            end
            2'd2: begin
                cos_q30 = -x;
                sin_q30 = -y;
            end
            default: begin
                cos_q30 = y;
                sin_q30 = -x;
            end
        endcase
    endfunction

    // Scale by the radius, round to an integer, add the center and saturate to signed Q15.0.
    function automatic logic signed [15:0] place_coord(input longint r,
                                                       input longint trig,
                                                       input longint center);
        longint v;
        v = ((r * trig + (64'sd1 <<< 29)) >>> 30) + center;
        if (v > rpvg_pkg::COORD_MAX)
            v = longint'(rpvg_pkg::COORD_MAX);
        else if (v < rpvg_pkg::COORD_MIN)
            v = longint'(rpvg_pkg::COORD_MIN);
        return v[15:0];
    endfunction

    task automatic predict_polygon(input logic [rpvg_pkg::SIDE_IN_W-1:0] sides,
                                   input logic [rpvg_pkg::RADIUS_W-1:0] r,
                                   input logic signed [15:0] cx,
                                   input logic signed [15:0] cy);
        int unsigned     n;
        longint unsigned full;
        longint unsigned phase;
        longint unsigned step;
        logic [31:0]     turn;
        longint          c;
        longint          s;
        t_vertex         v;
        // Too few sides produce nothing and leave the state alone.
        if (sides < rpvg_pkg::MIN_SIDES)
            return;
        n    = (sides > MAX_SIDES) ? MAX_SIDES : sides;
        full = 64'd1 << PHASE_BITS;
        step = full / n;
        phase_step = step[PHASE_BITS-1:0];
        polygons_seen++;
        for (int unsigned i = 0; i < n; i++) begin
            // i/n of a turn, rounded to nearest.
            phase = ((i * full + n / 2) / n) & (full - 1);
            turn  = 32'(phase << (32 - PHASE_BITS));
            rotate_turn(turn, c, s);
            v.x       = place_coord(r, c, cx);
            v.y       = place_coord(r, s, cy);
            v.last    = (i == n - 1);
            v.polygon = polygons_seen;
            v.corner  = i;
            expected_vertices = {expected_vertices, v};
            vertex_index      = i[5:0];
            phase_accumulator = phase[PHASE_BITS-1:0];
        end
    endtask

    task automatic report_mismatch(input string what);
        if (o_mismatches < PRINT_LIMIT)
            $display("[%0t] vertex check: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic check_vertex();
        t_vertex want;
        if (expected_vertices.size() == 0) begin
            report_mismatch($sformatf("unexpected vertex (%0d, %0d) last=%0b",
                                      i_vertex_x, i_vertex_y, i_last_vertex));
            return;
        end
        want = expected_vertices.pop_front();
        if (i_vertex_x !== want.x)
            report_mismatch($sformatf("polygon %0d vertex %0d: x %0d, expected %0d",
                                      want.polygon, want.corner, i_vertex_x, want.x));
        if (i_vertex_y !== want.y)
            report_mismatch($sformatf("polygon %0d vertex %0d: y %0d, expected %0d",
                                      want.polygon, want.corner, i_vertex_y, want.y));
        if (i_last_vertex !== want.last)
            report_mismatch($sformatf("polygon %0d vertex %0d: last %0b, expected %0b",
                                      want.polygon, want.corner, i_last_vertex,
                                      want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vertex_index      = '0;
            phase_accumulator = '0;
            phase_step        = '0;
        end else begin
            if (i_in_valid && i_in_ready)
                predict_polygon(i_side_count, i_radius, i_center_x, i_center_y);
            if (i_out_valid && i_out_ready)
                check_vertex();
        end
        // Published after the edge so that readers never race the update.
        o_pending <= expected_vertices.size();
    end

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// Regular polygon vertex generator testbench
// Sends directed and random polygon requests with random gaps and output
// stalls; a checker beside the block predicts and compares every vertex.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A 64-sided polygon keeps the block busy longest, so this many quiet cycles
    // after the last vertex is enough to catch any stray transaction.
    localparam int SETTLE_CYCLES = 1400;

    // The longest legal wait between two transactions is the division plus
    // the first vertex, stretched by a run of output stalls. The limit is many
    // times that.
    localparam int STALL_LIMIT = 4000;

    localparam int RANDOM_POLYGONS = 360;
    localparam int IDLE_PERCENT    = 36;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [rpvg_pkg::SIDE_IN_W-1:0]       side_count = '0;
    logic [rpvg_pkg::RADIUS_W-1:0]        radius = '0;
    logic signed [rpvg_pkg::COORD_W-1:0]  center_x = '0;
    logic signed [rpvg_pkg::COORD_W-1:0]  center_y = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [rpvg_pkg::COORD_W-1:0]  vertex_x;
    logic signed [rpvg_pkg::COORD_W-1:0]  vertex_y;
    logic                                 last_vertex;

    // While set, neither side inserts gaps or stalls.
    logic steady = 1'b0;

    int mismatches;
    int vertices_owed;
    int stall_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    regular_polygon_vertex_generator dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_side_count  (side_count),
        .i_radius      (radius),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_vertex_x    (vertex_x),
        .o_vertex_y    (vertex_y),
        .o_last_vertex (last_vertex)
    );

    vertex_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_side_count  (side_count),
        .i_radius      (radius),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_vertex_x    (vertex_x),
        .i_vertex_y    (vertex_y),
        .i_last_vertex (last_vertex),
        .o_mismatches  (mismatches),
        .o_pending     (vertices_owed)
    );

    // The receiver stalls on its own random schedule. Ready is free to drop
    // at any time, so it is redrawn on every falling edge.
    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog: a run that stops moving transactions has hung.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One request transaction. Gaps are inserted before the item, with valid
    // low; once valid rises it holds with a stable payload until the block
    // takes it. Only one assignment to valid happens per falling edge, so a
    // back-to-back item keeps valid high without a glitch.
    task automatic send_polygon(input logic [rpvg_pkg::SIDE_IN_W-1:0] sides,
                                input logic [rpvg_pkg::RADIUS_W-1:0] r,
                                input logic signed [15:0] cx,
                                input logic signed [15:0] cy);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        side_count <= sides;
        radius     <= r;
        center_x   <= cx;
        center_y   <= cy;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold off the sender until every predicted vertex has come back.
    task automatic drain_vertices();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (vertices_owed == 0);
    endtask

    // Centers favor the rails now and then so that the saturation on both
    // ends gets exercised.
    function automatic logic signed [15:0] rand_center();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 16'(16'sd32767 - $urandom_range(15));
        else if (pick < 16)
            return 16'(-16'sd32768 + $urandom_range(15));
        return 16'($urandom);
    endfunction

    initial begin
        int unsigned                    polygons_sent;
        int unsigned                    pick;
        logic [rpvg_pkg::SIDE_IN_W-1:0] sides;
        logic [rpvg_pkg::RADIUS_W-1:0]  r;

        polygons_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Side counts of zero, one and two must produce no
        // vertices at all.
        send_polygon(7'd0, 15'd100, 16'sd0, 16'sd0);
        send_polygon(7'd1, 15'd32767, 16'sd1000, -16'sd1000);
        send_polygon(7'd2, 15'd32767, -16'sd32768, 16'sd32767);
        // Triangle of radius 16384 around the origin.
        send_polygon(7'd3, 15'd16384, 16'sd0, 16'sd0);
        // Largest radius against the rails: both coordinates saturate.
        send_polygon(7'd4, 15'd32767, 16'sd32767, -16'sd32768);
        send_polygon(7'd4, 15'd32767, -16'sd32768, 16'sd32767);
        // Zero radius collapses every vertex onto the center.
        send_polygon(7'd5, 15'd0, 16'sd12345, -16'sd12345);
        send_polygon(7'd6, 15'd32767, 16'sd0, 16'sd0);
        // The most sides the block supports.
        send_polygon(7'd64, 15'd32767, 16'sd16384, -16'sd16384);
        // Above the maximum the side count is clamped to the maximum.
        send_polygon(7'd65, 15'd8192, 16'sd0, 16'sd0);
        send_polygon(7'd127, 15'd32767, -16'sd1, 16'sd1);
        send_polygon(7'd7, 15'd21845, 16'sd32767, 16'sd32767);
        send_polygon(7'd3, 15'd1, -16'sd32768, -16'sd32768);
        send_polygon(7'd12, 15'd16383, 16'sh5555, 16'sh2AAA);
        send_polygon(7'd8, 15'd10922, -16'sd20000, 16'sd20000);
        drain_vertices();

        // Random part. Most polygons are small to keep the run short; a
        // window in the middle runs with no gaps or stalls on either side.
        while (polygons_sent < RANDOM_POLYGONS) begin
            steady <= (polygons_sent >= 160) && (polygons_sent < 240);

            pick = $urandom_range(99);
            if (pick < 8)
                sides = 7'($urandom_range(2));
            else if (pick < 68)
                sides = 7'($urandom_range(12, 3));
            else if (pick < 88)
                sides = 7'($urandom_range(64, 13));
            else
                sides = 7'($urandom_range(127, 65));

            pick = $urandom_range(99);
            if (pick < 12)
                r = 15'(15'd32767 - $urandom_range(63));
            else if (pick < 20)
                r = 15'($urandom_range(15));
            else
                r = 15'($urandom_range(32767));

            send_polygon(sides, r, rand_center(), rand_center());

            // Only requests that produce vertices count toward the total.
            if (sides >= rpvg_pkg::MIN_SIDES) begin
                polygons_sent++;
                if (polygons_sent % 100 == 50)
                    drain_vertices();
            end
        end

        drain_vertices();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
